// File: sv/dss_pkg.sv
// Shared types, widths and codes for the detector stream selector.
package dss_pkg;

    localparam int CFG_W  = 11;  // width of the count registers
    localparam int PER_W  = 12;  // Z + X per interior round
    localparam int CNT_W  = 22;  // detector and kept counters
    localparam int COL_W  = 21;  // packed output column
    localparam int PROD_W = 23;  // interior rounds times detectors per round
    localparam int SPAN_W = 24;  // detector positions within a shot layout
    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    typedef enum logic [2:0] {
        REG_ROUND_CNT    = 3'd0,
        REG_NUM_Z_STABS  = 3'd1,
        REG_NUM_X_STABS  = 3'd2,
        REG_Z_BASIS_PREP = 3'd3,
        REG_KEEP_X       = 3'd4,
        REG_KEEP_Z       = 3'd5
    } reg_idx_t;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_NONE_KEPT = 2'd1,
        STATUS_MISMATCH  = 2'd2
    } status_t;

    typedef struct packed {
        logic [CFG_W-1:0]  num_z_stabs;
        logic [CFG_W-1:0]  num_x_stabs;
        logic [PER_W-1:0]  per_round;
        logic [PROD_W-1:0] interior_span;
        logic              z_basis_prep;
        logic              keep_x;
        logic              keep_z;
    } cfg_t;

    typedef struct packed {
        logic             kept_bit;
        logic             bit_valid;
        logic [COL_W-1:0] out_position;
        logic             shot_done;
        status_t          status;
    } res_t;

endpackage

// File: sv/dss_cfg.sv
// Configuration registers on the APB port and the derived layout span.
module dss_cfg
    import dss_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output cfg_t              cfg
);

    logic [CFG_W-1:0]  round_cnt_reg;
    logic [CFG_W-1:0]  num_z_stabs_reg;
    logic [CFG_W-1:0]  num_x_stabs_reg;
    logic              z_basis_prep_reg;
    logic              keep_x_reg;
    logic              keep_z_reg;
    logic [PROD_W-1:0] span_reg;
    logic [PROD_W-1:0] span_next;
    logic [CFG_W-1:0]  interior;
    logic [PER_W-1:0]  per_round;
    logic              wr_en;
    reg_idx_t          reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_sel = reg_idx_t'(paddr[ADDR_W-1:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            round_cnt_reg    <= CFG_W'(1);
            num_z_stabs_reg  <= '0;
            num_x_stabs_reg  <= '0;
            z_basis_prep_reg <= 1'b1;
            keep_x_reg       <= 1'b1;
            keep_z_reg       <= 1'b1;
        end
        else if (wr_en)
        begin
            unique case (reg_sel)
                REG_ROUND_CNT:    round_cnt_reg    <= pwdata[CFG_W-1:0];
                REG_NUM_Z_STABS:  num_z_stabs_reg  <= pwdata[CFG_W-1:0];
                REG_NUM_X_STABS:  num_x_stabs_reg  <= pwdata[CFG_W-1:0];
                REG_Z_BASIS_PREP: z_basis_prep_reg <= pwdata[0];
                REG_KEEP_X:       keep_x_reg       <= pwdata[0];
                REG_KEEP_Z:       keep_z_reg       <= pwdata[0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            REG_ROUND_CNT:    prdata = DATA_W'(round_cnt_reg);
            REG_NUM_Z_STABS:  prdata = DATA_W'(num_z_stabs_reg);
            REG_NUM_X_STABS:  prdata = DATA_W'(num_x_stabs_reg);
            REG_Z_BASIS_PREP: prdata = DATA_W'(z_basis_prep_reg);
            REG_KEEP_X:       prdata = DATA_W'(keep_x_reg);
            REG_KEEP_Z:       prdata = DATA_W'(keep_z_reg);
            default:          prdata = '0;
        endcase
    end

    // interior rounds = rounds - 1, floored at zero
    assign interior  = (round_cnt_reg == '0) ? '0 : round_cnt_reg - CFG_W'(1);
    assign per_round = PER_W'(num_z_stabs_reg) + PER_W'(num_x_stabs_reg);
    assign span_next = PROD_W'(interior) * PROD_W'(per_round);

    // Registered in the cycle after a write; until then the span holds its old value.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            span_reg <= '0;
        else
            span_reg <= span_next;
    end

    always_comb
    begin
        cfg.num_z_stabs   = num_z_stabs_reg;
        cfg.num_x_stabs   = num_x_stabs_reg;
        cfg.per_round     = per_round;
        cfg.interior_span = span_reg;
        cfg.z_basis_prep  = z_basis_prep_reg;
        cfg.keep_x        = keep_x_reg;
        cfg.keep_z        = keep_z_reg;
    end

endmodule

// File: sv/dss_core.sv
// Input register, keep decision and per-shot counters.
module dss_core
    import dss_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic syn_valid,
    output logic syn_ready,
    input  logic syndrome_bit,
    input  logic shot_end,
    input  cfg_t cfg,
    input  logic adv,
    output logic res_push,
    output res_t res
);

    logic             in_valid_reg;
    logic             in_valid_next;
    logic             bit_reg;
    logic             end_reg;
    logic [CNT_W-1:0] det_idx_reg;
    logic [CNT_W-1:0] det_idx_next;
    logic [PER_W-1:0] pos_reg;
    logic [PER_W-1:0] pos_next;
    logic [CNT_W-1:0] kept_reg;
    logic [CNT_W-1:0] kept_next;

    logic              accept;
    logic              fire;
    logic [CFG_W-1:0]  fixed;
    logic [SPAN_W-1:0] idx_w;
    logic [SPAN_W-1:0] interior_end;
    logic [SPAN_W-1:0] expected;
    logic              in_head;
    logic              before_int_end;
    logic              before_exp;
    logic              in_interior;
    logic              fixed_kept;
    logic              keep_both;
    logic              keep_one;
    logic              is_z;
    logic              keep;
    logic [PER_W:0]    pos_inc;
    logic              mismatch;

    assign syn_ready = !in_valid_reg || adv;
    assign accept    = syn_valid && syn_ready;
    assign fire      = in_valid_reg && adv;

    always_comb
    begin
        if (accept)
            in_valid_next = 1'b1;
        else if (adv)
            in_valid_next = 1'b0;
        else
            in_valid_next = in_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else
            in_valid_reg <= in_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            bit_reg <= syndrome_bit;
            end_reg <= shot_end;
        end
    end

    // Layout: head boundary, interior rounds, tail boundary.
    assign fixed        = cfg.z_basis_prep ? cfg.num_z_stabs : cfg.num_x_stabs;
    assign idx_w        = SPAN_W'(det_idx_reg);
    assign interior_end = SPAN_W'(cfg.interior_span) + SPAN_W'(fixed);
    assign expected     = SPAN_W'(cfg.interior_span) + SPAN_W'({fixed, 1'b0});

    assign in_head        = idx_w < SPAN_W'(fixed);
    assign before_int_end = idx_w < interior_end;
    assign before_exp     = idx_w < expected;
    assign in_interior    = !in_head && before_int_end;

    assign fixed_kept = cfg.z_basis_prep ? cfg.keep_z : cfg.keep_x;
    assign keep_both  = cfg.keep_x && cfg.keep_z;
    assign keep_one   = cfg.keep_x ^ cfg.keep_z;
    assign is_z       = pos_reg < PER_W'(cfg.num_z_stabs);

    always_comb
    begin
        keep = 1'b0;
        if (keep_both)
            keep = 1'b1;
        else if (keep_one)
        begin
            priority if (in_head)
                keep = fixed_kept;
            else if (before_int_end)
                keep = is_z ? cfg.keep_z : cfg.keep_x;
            else if (before_exp)
                keep = fixed_kept;
            else
                keep = 1'b0;
        end
    end

    // overflowed detector counter counts as a mismatch too
    assign mismatch = (det_idx_reg == CNT_MAX) || ((idx_w + SPAN_W'(1)) != expected);

    always_comb
    begin
        res.kept_bit     = keep & bit_reg;
        res.bit_valid    = keep;
        res.out_position = keep ? kept_reg[COL_W-1:0] : '0;
        res.shot_done    = end_reg;
        res.status       = STATUS_OK;
        if (end_reg)
        begin
            if (!cfg.keep_x && !cfg.keep_z)
                res.status = STATUS_NONE_KEPT;
            else if (keep_one && mismatch)
                res.status = STATUS_MISMATCH;
        end
    end

    assign res_push = fire && (keep || end_reg);
    assign pos_inc  = {1'b0, pos_reg} + (PER_W+1)'(1);

    always_comb
    begin
        det_idx_next = det_idx_reg;
        pos_next     = pos_reg;
        kept_next    = kept_reg;
        if (in_interior)
            pos_next = (pos_inc >= {1'b0, cfg.per_round}) ? '0 : pos_inc[PER_W-1:0];
        if (keep && kept_reg != CNT_MAX)
            kept_next = kept_reg + CNT_W'(1);
        if (det_idx_reg != CNT_MAX)
            det_idx_next = det_idx_reg + CNT_W'(1);
        if (end_reg)
        begin
            det_idx_next = '0;
            pos_next     = '0;
            kept_next    = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            det_idx_reg <= '0;
            pos_reg     <= '0;
            kept_reg    <= '0;
        end
        else if (fire)
        begin
            det_idx_reg <= det_idx_next;
            pos_reg     <= pos_next;
            kept_reg    <= kept_next;
        end
    end

endmodule

// File: sv/dss_out.sv
// Result register toward the output channel.
module dss_out
    import dss_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             res_push,
    input  res_t             res,
    output logic             adv,
    output logic             res_valid,
    input  logic             res_ready,
    output logic             kept_bit,
    output logic             bit_valid,
    output logic [COL_W-1:0] out_position,
    output logic             shot_done,
    output logic [1:0]       status
);

    logic res_valid_reg;
    logic res_valid_next;
    res_t res_reg;

    assign adv = !res_valid_reg || res_ready;

    always_comb
    begin
        if (res_push)
            res_valid_next = 1'b1;
        else if (res_ready)
            res_valid_next = 1'b0;
        else
            res_valid_next = res_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else
            res_valid_reg <= res_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (res_push)
            res_reg <= res;
    end

    assign res_valid    = res_valid_reg;
    assign kept_bit     = res_reg.kept_bit;
    assign bit_valid    = res_reg.bit_valid;
    assign out_position = res_reg.out_position;
    assign shot_done    = res_reg.shot_done;
    assign status       = res_reg.status;

endmodule

// File: sv/detector_stream_selector.sv
// Top level of the detector stream selector.
// Usage:
//   Detector bits enter one per transaction on the syn channel (syn_valid /
//   syn_ready, fields syndrome_bit and shot_end). Kept bits leave on the res
//   channel (res_valid / res_ready) with their packed column; the transaction
//   carrying shot_end always yields one result with shot_done and status.
//   Bits that are dropped produce no result.
// Path: an input transaction passes the input register, then the result
//   register; res_valid rises when the result enters the result register.
// Throughput: one detector per cycle unless res_ready stalls; the keep decision
//   and counter updates are one short pass between the two registers.
// Reset: counters clear, both stages empty, registers take their defaults.
// Stall: while res_ready is low the result register holds; the input
//   register still takes one more transaction, then syn_ready drops.
// Configuration uses the APB port; the derived layout span is registered and
//   updates in the cycle after a write.
module detector_stream_selector
    import dss_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    input  logic              syn_valid,
    output logic              syn_ready,
    input  logic              syndrome_bit,
    input  logic              shot_end,
    output logic              res_valid,
    input  logic              res_ready,
    output logic              kept_bit,
    output logic              bit_valid,
    output logic [COL_W-1:0]  out_position,
    output logic              shot_done,
    output logic [1:0]        status
);

    cfg_t cfg;
    res_t res;
    logic res_push;
    logic adv;

    dss_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    dss_core u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .syn_valid    (syn_valid),
        .syn_ready    (syn_ready),
        .syndrome_bit (syndrome_bit),
        .shot_end     (shot_end),
        .cfg          (cfg),
        .adv          (adv),
        .res_push     (res_push),
        .res          (res)
    );

    dss_out u_out (
        .clk          (clk),
        .rst_n        (rst_n),
        .res_push     (res_push),
        .res          (res),
        .adv          (adv),
        .res_valid    (res_valid),
        .res_ready    (res_ready),
        .kept_bit     (kept_bit),
        .bit_valid    (bit_valid),
        .out_position (out_position),
        .shot_done    (shot_done),
        .status       (status)
    );

endmodule
